@@ rtl/mhpq_pkg.sv @@
// Shared constants, codes and controller/datapath interface structs
// for the binary max-heap priority queue. No dependencies.
package mhpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_W      = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int STATUS_W   = 2;
  localparam int OUT_DATA_W = ((KEY_W + CNT_W + 7) / 8) * 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic                load_ins;     // count+1, park key at the new slot
    logic                rd_remove;    // read root and last slot
    logic                latch_rem;    // keep root, take last as key, count-1
    logic                rd_parent;    // read parent of pos
    logic                up_move;      // parent moves down into pos
    logic                rd_children;  // read both children of pos
    logic                dn_move;      // larger child moves up into pos
    logic                wr_key;       // write held key at pos
    logic                res_set;      // capture the result
    logic                res_top;      // result carries the removed root
    logic [STATUS_W-1:0] res_status;
    logic                out_load;     // move result into output register
  } mhpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_root;
    logic parent_lt;
    logic has_left;
    logic child_gt;
    logic out_free;
  } mhpq_sts_t;

endpackage

@@ rtl/max_heap_priority_queue_core.sv @@
// Top level of the binary max-heap priority queue: stream ports, controller
// and datapath. Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tuser[0]=func, tdata[31:0]=value
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0]=max_value,
//                                               tdata[38:32]=count_after,
//                                               tuser[1:0]=status
//
// A dropped insert or an empty remove goes straight to the result; each heap
// level walked is a registered key-store read, then a compare and write, for
// up to 6 levels.
// One request is in work at a time; s_axis_tready is high only while idle.
// A finished result waits in the output register while the next request
// is accepted; if that register is still full at the end of the next
// request, the core holds until m_axis_tready frees it.
// Reset empties the heap (count to zero); the key store itself is not cleared.
module max_heap_priority_queue_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [mhpq_pkg::KEY_W-1:0]            s_axis_tdata,   // [31:0] value
  input  logic [0:0]                            s_axis_tuser,   // [0] func
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [mhpq_pkg::OUT_DATA_W-1:0]       m_axis_tdata,   // [31:0] max_value,
                                                                // [38:32] count_after
  output logic [mhpq_pkg::STATUS_W-1:0]         m_axis_tuser    // [1:0] status
);
  import mhpq_pkg::*;

  mhpq_cmd_t               cmd;
  mhpq_sts_t               sts;
  logic signed [KEY_W-1:0] out_max;
  logic [STATUS_W-1:0]     out_status;
  logic [CNT_W-1:0]        out_count;

  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mhpq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_max_o    (out_max),
    .out_status_o (out_status),
    .out_count_o  (out_count)
  );

  // pack result: max_value low, count_after above it, zero pad to bytes
  assign m_axis_tdata = OUT_DATA_W'({out_count, out_max});
  assign m_axis_tuser = out_status;

endmodule

@@ rtl/mhpq_ctrl.sv @@
// Sequencer for the heap: accepts requests and steps sift-up/sift-down.
// Depends on mhpq_pkg; drives the datapath through mhpq_cmd_t.
module mhpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_op_i,
  output logic               in_ready_o,
  input  mhpq_pkg::mhpq_sts_t sts_i,
  output mhpq_pkg::mhpq_cmd_t cmd_o
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CHK = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_REM_LD = 3'd3;
  localparam logic [2:0] S_DN_CHK = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_op_i == OP_INSERT) begin
            if (sts_i.full) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_FULL;
              state_d          = S_DONE;
            end else begin
              cmd_o.load_ins = 1'b1;
              state_d        = S_UP_CHK;
            end
          end else begin
            if (sts_i.empty) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = ST_EMPTY;
              state_d          = S_DONE;
            end else begin
              cmd_o.rd_remove = 1'b1;
              state_d         = S_REM_LD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts_i.pos_root) begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts_i.parent_lt) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_CHK;
        end else begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.res_set = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_REM_LD: begin
        cmd_o.latch_rem = 1'b1;
        state_d         = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts_i.has_left) begin
          cmd_o.rd_children = 1'b1;
          state_d           = S_DN_CMP;
        end else begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.res_top = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DN_CMP: begin
        if (sts_i.child_gt) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_CHK;
        end else begin
          cmd_o.wr_key  = 1'b1;
          cmd_o.res_set = 1'b1;
          cmd_o.res_top = 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/mhpq_dp.sv @@
// Heap datapath: key store, element count, sift registers and compares,
// result and output registers. Depends on mhpq_pkg.
module mhpq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [mhpq_pkg::KEY_W-1:0] value_i,
  input  mhpq_pkg::mhpq_cmd_t               cmd_i,
  output mhpq_pkg::mhpq_sts_t               sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mhpq_pkg::KEY_W-1:0] out_max_o,
  output logic [mhpq_pkg::STATUS_W-1:0]     out_status_o,
  output logic [mhpq_pkg::CNT_W-1:0]        out_count_o
);
  import mhpq_pkg::*;

  logic [KEY_W-1:0]        mem_q [CAPACITY];

  logic [CNT_W-1:0]        count_q, pos_q;
  logic signed [KEY_W-1:0] key_q, top_q, rd_a_q, rd_b_q;
  logic signed [KEY_W-1:0] res_max_q;
  logic [STATUS_W-1:0]     res_status_q;
  logic                    out_valid_q;

  logic [CNT_W:0]          left_idx, right_idx;
  logic [CNT_W-1:0]        parent_idx, best_idx;
  logic                    has_left, has_right, pick_right;
  logic signed [KEY_W-1:0] best;
  logic [ADDR_W-1:0]       rd_addr_a, rd_addr_b, wr_addr;
  logic [KEY_W-1:0]        wr_data;
  logic                    rd_en, wr_en;

  // slot n of the 1-based heap lives at address n-1
  assign left_idx   = {pos_q, 1'b0};
  assign right_idx  = left_idx + 1'b1;
  assign parent_idx = pos_q >> 1;
  assign has_left   = left_idx  <= {1'b0, count_q};
  assign has_right  = right_idx <= {1'b0, count_q};
  assign pick_right = has_right && (rd_b_q > rd_a_q);
  assign best       = pick_right ? rd_b_q : rd_a_q;
  assign best_idx   = pick_right ? right_idx[CNT_W-1:0] : left_idx[CNT_W-1:0];

  always_comb begin
    rd_addr_a = ADDR_W'(parent_idx - 1'b1);
    rd_addr_b = ADDR_W'(right_idx - 1'b1);
    if (cmd_i.rd_children) begin
      rd_addr_a = ADDR_W'(left_idx - 1'b1);
    end else if (cmd_i.rd_remove) begin
      rd_addr_a = '0;
      rd_addr_b = ADDR_W'(count_q - 1'b1);
    end
  end

  assign rd_en   = cmd_i.rd_parent | cmd_i.rd_children | cmd_i.rd_remove;
  assign wr_en   = cmd_i.up_move | cmd_i.dn_move | cmd_i.wr_key;
  assign wr_addr = ADDR_W'(pos_q - 1'b1);

  always_comb begin
    wr_data = key_q;
    if (cmd_i.up_move) begin
      wr_data = rd_a_q;
    end else if (cmd_i.dn_move) begin
      wr_data = best;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[rd_addr_a];
      rd_b_q <= mem_q[rd_addr_b];
    end
  end

  // sift registers and result capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ins) begin
      key_q <= value_i;
      pos_q <= count_q + 1'b1;
    end
    if (cmd_i.latch_rem) begin
      top_q <= rd_a_q;
      key_q <= rd_b_q;
      pos_q <= CNT_W'(1);
    end
    if (cmd_i.up_move) begin
      pos_q <= parent_idx;
    end
    if (cmd_i.dn_move) begin
      pos_q <= best_idx;
    end
    if (cmd_i.res_set) begin
      res_max_q    <= cmd_i.res_top ? top_q : '0;
      res_status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      out_max_o    <= res_max_q;
      out_status_o <= res_status_q;
      out_count_o  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_ins) begin
        count_q <= count_q + 1'b1;
      end else if (cmd_i.latch_rem) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.full      = count_q == CNT_W'(CAPACITY);
  assign sts_o.empty     = count_q == '0;
  assign sts_o.pos_root  = pos_q == CNT_W'(1);
  assign sts_o.parent_lt = key_q > rd_a_q;
  assign sts_o.has_left  = has_left;
  assign sts_o.child_gt  = best > key_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ rtl/mhpq_checker.sv @@
// Port-level checks for max_heap_priority_queue_core, bound to the top level.
// Depends on mhpq_pkg.
module mhpq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [mhpq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [mhpq_pkg::STATUS_W-1:0]   m_axis_tuser
);
  import mhpq_pkg::*;

  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] maxv;

  assign cnt  = m_axis_tdata[KEY_W +: CNT_W];
  assign maxv = m_axis_tdata[KEY_W-1:0];

  // one request at a time: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // a full drop reports a full heap, an empty remove an empty one, an ok result a count up to CAPACITY
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ST_OK && cnt <= CNT_W'(CAPACITY)) ||
                       (m_axis_tuser == ST_FULL && cnt == CNT_W'(CAPACITY)) ||
                       (m_axis_tuser == ST_EMPTY && cnt == '0)))
    else $error("status and count disagree");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_OK) |-> maxv == '0)
    else $error("failed request carries a nonzero key");

  // count moves by at most one between consecutive results
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) ##1 (m_axis_tvalid && !$stable(m_axis_tdata))
      |-> (cnt == $past(cnt) || cnt == $past(cnt) + 1'b1 || cnt + 1'b1 == $past(cnt)))
    else $error("count jumped between results");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
